[sv/key_debounce_long_press_chord_assert.svh]
// assertion macros for the key debounce block
// expects signals named clock and reset in the module that uses them
`ifndef KEY_DEBOUNCE_LONG_PRESS_CHORD_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_CHORD_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KDLP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define KDLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/kdlp_pkg.sv]
// shared types and constants for the key debounce block
// no dependencies
`default_nettype none

package kdlp_pkg;

   // key count and derived widths
   localparam int KEY_COUNT  = 3;
   localparam int KEY_IDX_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int SLOT_COUNT = 2 * KEY_COUNT;
   localparam int SLOT_W     = KEY_IDX_W + 1;

   // field widths
   localparam int KEY_NUM_W  = 2;
   localparam int EVENT_W    = 2;
   localparam int SAMPLE_W   = 8;
   localparam int INTERVAL_W = 8;
   localparam int HOLD_W     = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - KEY_NUM_W - EVENT_W;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

   // register reset values
   localparam logic [SAMPLE_W-1:0]   PRESS_SAMPLES_RST = 8'd3;
   localparam logic [INTERVAL_W-1:0] SCAN_INTERVAL_RST = 8'd10;
   localparam logic [HOLD_W-1:0]     LONG_PRESS_RST    = 16'd1000;
   localparam logic [HOLD_W-1:0]     LONG_MARGIN_RST   = 16'd100;

   typedef enum logic [EVENT_W-1:0] {
      EV_SHORT = 2'd0,
      EV_LONG  = 2'd1,
      EV_OFF   = 2'd2
   } event_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESS_SAMPLES = 2'd0,
      CSR_SCAN_INTERVAL = 2'd1,
      CSR_LONG_PRESS    = 2'd2,
      CSR_LONG_MARGIN   = 2'd3
   } csr_index_type;

   // tracking state of one key
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_count;
      logic                confirmed;
      logic                long_sent;
      logic [HOLD_W-1:0]   hold_time;
      logic                suppressed;
   } key_state_type;

   // events of one scan: slot 2k is long or short of key k, slot 2k+1 is its release
   typedef struct packed {
      logic [SLOT_COUNT-1:0] pending;
      logic [KEY_COUNT-1:0]  first_long;
   } scan_events_type;

endpackage

`default_nettype wire

[sv/key_debounce_long_press_chord.sv]
// key debounce with short and long press events and chord suppression, top level
// an accepted scan item waits in the input register until the event buffer is free,
// then commits into the buffer; its events leave through the output register
// throughput: one scan per cycle while the buffer is free; up to 6 events per scan
// reset: synchronous, clears key state, buffers and valids; registers get default values
// depends on kdlp_pkg, kdlp_scan and kdlp_event_queue
`default_nettype none

module key_debounce_long_press_chord (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [2:0] raw_pressed, [7:3] zero
   input  wire logic [kdlp_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [1:0] key_number, [3:2] event_type, [7:4] zero
   output logic [kdlp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [kdlp_pkg::CSR_IDX_W-1:0]    csr_windex,
   input  wire logic [kdlp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                            in_valid_ff;
   logic                            in_valid_in;
   logic [kdlp_pkg::KEY_COUNT-1:0]  raw_ff;
   logic                            req_fire;
   logic                            buf_free;
   logic                            scan_commit;
   kdlp_pkg::scan_events_type       events;

   // input register handshake
   always_comb begin
      req_tready  = !in_valid_ff || buf_free;
      req_fire    = req_tvalid && req_tready;
      scan_commit = in_valid_ff && buf_free;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (scan_commit) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         raw_ff <= req_tdata[kdlp_pkg::KEY_COUNT-1:0];
      end
   end

   // scan logic and key state
   kdlp_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_windex  (csr_windex),
      .csr_wdata   (csr_wdata),
      .scan_commit (scan_commit),
      .raw         (raw_ff),
      .events      (events)
   );

   // event buffer and output register
   kdlp_event_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .scan_commit (scan_commit),
      .events      (events),
      .buf_free    (buf_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

[sv/kdlp_scan.sv]
// per-key debounce, hold timing, chord suppression and event flags for one scan
// depends on kdlp_pkg
`default_nettype none

module kdlp_scan (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [kdlp_pkg::CSR_IDX_W-1:0]    csr_windex,
   input  wire logic [kdlp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              scan_commit,
   input  wire logic [kdlp_pkg::KEY_COUNT-1:0]    raw,
   output kdlp_pkg::scan_events_type              events
);

   // configuration registers
   logic [kdlp_pkg::SAMPLE_W-1:0]   press_samples_ff;
   logic [kdlp_pkg::INTERVAL_W-1:0] scan_interval_ff;
   logic [kdlp_pkg::HOLD_W-1:0]     long_press_ff;
   logic [kdlp_pkg::HOLD_W-1:0]     long_margin_ff;

   // key state
   kdlp_pkg::key_state_type key_ff [kdlp_pkg::KEY_COUNT];
   kdlp_pkg::key_state_type key_in [kdlp_pkg::KEY_COUNT];
   kdlp_pkg::key_state_type phase1 [kdlp_pkg::KEY_COUNT];
   kdlp_pkg::key_state_type phase2 [kdlp_pkg::KEY_COUNT];

   logic [kdlp_pkg::HOLD_W:0]       hold_sum   [kdlp_pkg::KEY_COUNT];
   logic [kdlp_pkg::SAMPLE_W-1:0]   count_up   [kdlp_pkg::KEY_COUNT];
   logic [kdlp_pkg::HOLD_W:0]       margin_sum [kdlp_pkg::KEY_COUNT];
   logic [kdlp_pkg::KEY_COUNT-1:0]  down;
   logic                            chord_hit;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         press_samples_ff <= kdlp_pkg::PRESS_SAMPLES_RST;
         scan_interval_ff <= kdlp_pkg::SCAN_INTERVAL_RST;
         long_press_ff    <= kdlp_pkg::LONG_PRESS_RST;
         long_margin_ff   <= kdlp_pkg::LONG_MARGIN_RST;
      end else if (csr_we) begin
         case (kdlp_pkg::csr_index_type'(csr_windex))
            kdlp_pkg::CSR_PRESS_SAMPLES: begin
               press_samples_ff <= csr_wdata[kdlp_pkg::SAMPLE_W-1:0];
            end
            kdlp_pkg::CSR_SCAN_INTERVAL: begin
               scan_interval_ff <= csr_wdata[kdlp_pkg::INTERVAL_W-1:0];
            end
            kdlp_pkg::CSR_LONG_PRESS: begin
               long_press_ff <= csr_wdata[kdlp_pkg::HOLD_W-1:0];
            end
            kdlp_pkg::CSR_LONG_MARGIN: begin
               long_margin_ff <= csr_wdata[kdlp_pkg::HOLD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // debounce and hold time update
   always_comb begin
      for (int k = 0; k < kdlp_pkg::KEY_COUNT; k++) begin
         hold_sum[k] = {1'b0, key_ff[k].hold_time}
                     + (kdlp_pkg::HOLD_W + 1)'(scan_interval_ff);
         count_up[k] = (key_ff[k].sample_count < press_samples_ff)
                     ? key_ff[k].sample_count + kdlp_pkg::SAMPLE_W'(1)
                     : key_ff[k].sample_count;
         phase1[k] = key_ff[k];
         if (!raw[k]) begin
            phase1[k].suppressed = 1'b0;
            if (!key_ff[k].confirmed) begin
               phase1[k].sample_count = '0;
            end
         end else if (key_ff[k].confirmed) begin
            phase1[k].hold_time = hold_sum[k][kdlp_pkg::HOLD_W]
                                ? kdlp_pkg::HOLD_MAX
                                : hold_sum[k][kdlp_pkg::HOLD_W-1:0];
         end else if (!key_ff[k].suppressed) begin
            phase1[k].sample_count = count_up[k];
            if (count_up[k] >= press_samples_ff) begin
               phase1[k].confirmed = 1'b1;
               phase1[k].long_sent = 1'b0;
               phase1[k].hold_time = '0;
            end
         end
      end
   end

   // chord detection, key 0 has priority
   always_comb begin
      down[0] = raw[0] && phase1[0].confirmed;
      for (int k = 1; k < kdlp_pkg::KEY_COUNT; k++) begin
         down[k] = raw[k] && (phase1[k].confirmed || phase1[k].suppressed);
      end
      chord_hit = down[0] || ($countones(down[kdlp_pkg::KEY_COUNT-1:1]) >= 2);
      for (int k = 0; k < kdlp_pkg::KEY_COUNT; k++) begin
         phase2[k] = phase1[k];
         if (k > 0 && chord_hit && down[k]) begin
            phase2[k].suppressed   = 1'b1;
            phase2[k].sample_count = '0;
            phase2[k].confirmed    = 1'b0;
            phase2[k].long_sent    = 1'b0;
            phase2[k].hold_time    = '0;
         end
      end
   end

   // long while held, and release events
   always_comb begin
      events.pending    = '0;
      events.first_long = '0;
      for (int k = 0; k < kdlp_pkg::KEY_COUNT; k++) begin
         key_in[k]     = phase2[k];
         margin_sum[k] = {1'b0, phase2[k].hold_time} + {1'b0, long_margin_ff};
         if (!phase2[k].suppressed && phase2[k].confirmed) begin
            if (raw[k]) begin
               if (!phase2[k].long_sent && phase2[k].hold_time >= long_press_ff) begin
                  key_in[k].long_sent  = 1'b1;
                  events.pending[2*k]  = 1'b1;
                  events.first_long[k] = 1'b1;
               end
            end else begin
               key_in[k].sample_count = '0;
               key_in[k].confirmed    = 1'b0;
               key_in[k].long_sent    = 1'b0;
               key_in[k].hold_time    = '0;
               if (!phase2[k].long_sent) begin
                  if (phase2[k].hold_time >= long_press_ff) begin
                     events.pending[2*k]  = 1'b1;
                     events.first_long[k] = 1'b1;
                  end else if (margin_sum[k] < {1'b0, long_press_ff}) begin
                     events.pending[2*k]  = 1'b1;
                  end
               end
               events.pending[2*k+1] = 1'b1;
            end
         end
      end
   end

   // key state registers, updated once per committed scan
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < kdlp_pkg::KEY_COUNT; k++) begin
            key_ff[k] <= '0;
         end
      end else if (scan_commit) begin
         for (int k = 0; k < kdlp_pkg::KEY_COUNT; k++) begin
            key_ff[k] <= key_in[k];
         end
      end
   end

endmodule

`default_nettype wire

[sv/kdlp_event_queue.sv]
// holds one scan's events, gives one item per cycle unless stalled
// depends on kdlp_pkg and key_debounce_long_press_chord_assert.svh
`default_nettype none
`include "key_debounce_long_press_chord_assert.svh"

module kdlp_event_queue (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              scan_commit,
   input  wire kdlp_pkg::scan_events_type         events,
   output logic                                   buf_free,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [1:0] key_number, [3:2] event_type, [7:4] zero
   output logic [kdlp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast
);

   logic [kdlp_pkg::SLOT_COUNT-1:0] pending_ff;
   logic [kdlp_pkg::SLOT_COUNT-1:0] pending_in;
   logic [kdlp_pkg::KEY_COUNT-1:0]  first_long_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [kdlp_pkg::KEY_NUM_W-1:0]  rsp_key_ff;
   kdlp_pkg::event_kind_type        rsp_kind_ff;
   logic                            rsp_last_ff;

   logic [kdlp_pkg::SLOT_COUNT-1:0] pick_onehot;
   logic [kdlp_pkg::SLOT_COUNT-1:0] rest;
   logic [kdlp_pkg::SLOT_W-1:0]     pick_idx;
   logic [kdlp_pkg::KEY_IDX_W-1:0]  pick_key;
   kdlp_pkg::event_kind_type        pick_kind;
   logic                            out_free;
   logic                            pop;
   logic                            pop_last;

   // lowest pending slot goes next
   always_comb begin
      pick_onehot = pending_ff & (~pending_ff + kdlp_pkg::SLOT_COUNT'(1));
      rest        = pending_ff & ~pick_onehot;
      pick_idx    = '0;
      for (int s = kdlp_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
         if (pending_ff[s]) begin
            pick_idx = kdlp_pkg::SLOT_W'(s);
         end
      end
      pick_key = pick_idx[kdlp_pkg::SLOT_W-1:1];
      if (pick_idx[0]) begin
         pick_kind = kdlp_pkg::EV_OFF;
      end else if (first_long_ff[pick_key]) begin
         pick_kind = kdlp_pkg::EV_LONG;
      end else begin
         pick_kind = kdlp_pkg::EV_SHORT;
      end
   end

   // handshake between buffer and output register
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      pop          = out_free && (pending_ff != '0);
      pop_last     = pop && (rest == '0);
      buf_free     = (pending_ff == '0) || pop_last;
      rsp_valid_in = out_free ? pop : rsp_valid_ff;
      if (scan_commit) begin
         pending_in = events.pending;
      end else if (pop) begin
         pending_in = rest;
      end else begin
         pending_in = pending_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (scan_commit) begin
         first_long_ff <= events.first_long;
      end
      if (pop) begin
         rsp_key_ff  <= kdlp_pkg::KEY_NUM_W'(pick_key);
         rsp_kind_ff <= pick_kind;
         rsp_last_ff <= (rest == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {kdlp_pkg::RSP_PAD_W'(0), rsp_kind_ff, rsp_key_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a shown item that is not last has followers still buffered
   `KDLP_ASSERT_IMPLY(a_more_pending, rsp_valid_ff && !rsp_last_ff, pending_ff != '0, "non-last item with empty buffer")
   // a new scan only enters a buffer that is empty or drains this cycle
   `KDLP_ASSERT_IMPLY(a_commit_free, scan_commit, buf_free, "scan committed into busy buffer")
   // without a new scan no slot appears
   `KDLP_ASSERT_NEXT(a_no_new_slot, !scan_commit, (pending_ff & ~$past(pending_ff)) == '0, "slot appeared without scan")
   // at most one slot leaves per cycle
   `KDLP_ASSERT_NEXT(a_single_pop, !scan_commit, $countones($past(pending_ff)) <= $countones(pending_ff) + 1, "more than one slot popped")

endmodule

`default_nettype wire

[tb/tb_key_debounce_long_press_chord.sv]
`timescale 1ns / 1ps
// self-checking bench for the key debounce block: drives scan items, predicts events
// and compares them on the result stream; depends on kdlp_pkg and the block's top level

module tb_key_debounce_long_press_chord;

   // one expected or observed key event
   typedef struct packed {
      logic [kdlp_pkg::KEY_NUM_W-1:0] key;
      kdlp_pkg::event_kind_type       kind;
      logic                           last;
   } key_event_type;

   // scans at reset values: all keys, key 0 with key 1 chorded, keys 1 and 2 chorded,
   // then a plain short press of key 2
   localparam logic [kdlp_pkg::KEY_COUNT-1:0] DIRECTED_SCANS [22] = '{
      3'd7, 3'd0,
      3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd1, 3'd0,
      3'd2, 3'd2, 3'd2, 3'd6, 3'd6, 3'd6, 3'd0,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd0
   };

   // key state predictor and queue of events still to arrive
   class key_event_tracker;
      logic [kdlp_pkg::SAMPLE_W-1:0]   press_samples;
      logic [kdlp_pkg::INTERVAL_W-1:0] scan_ms;
      logic [kdlp_pkg::HOLD_W-1:0]     long_ms;
      logic [kdlp_pkg::HOLD_W-1:0]     margin_ms;
      logic [kdlp_pkg::SAMPLE_W-1:0]   sample_cnt [kdlp_pkg::KEY_COUNT];
      bit                              confirmed  [kdlp_pkg::KEY_COUNT];
      bit                              long_done  [kdlp_pkg::KEY_COUNT];
      logic [kdlp_pkg::HOLD_W-1:0]     held_ms    [kdlp_pkg::KEY_COUNT];
      bit                              muted      [kdlp_pkg::KEY_COUNT];
      key_event_type                   expected_events [$];
      int                              fail_count;

      function new();
         press_samples = kdlp_pkg::PRESS_SAMPLES_RST;
         scan_ms       = kdlp_pkg::SCAN_INTERVAL_RST;
         long_ms       = kdlp_pkg::LONG_PRESS_RST;
         margin_ms     = kdlp_pkg::LONG_MARGIN_RST;
         for (int k = 0; k < kdlp_pkg::KEY_COUNT; k++) begin
            clear_key(k);
            muted[k] = 1'b0;
         end
         fail_count = 0;
      endfunction

      function void set_regs(logic [kdlp_pkg::SAMPLE_W-1:0] ps,
                             logic [kdlp_pkg::INTERVAL_W-1:0] si,
                             logic [kdlp_pkg::HOLD_W-1:0] lp,
                             logic [kdlp_pkg::HOLD_W-1:0] lm);
         press_samples = ps;
         scan_ms       = si;
         long_ms       = lp;
         margin_ms     = lm;
      endfunction

      function void clear_key(int k);
         sample_cnt[k] = '0;
         confirmed[k]  = 1'b0;
         long_done[k]  = 1'b0;
         held_ms[k]    = '0;
      endfunction

      function key_event_type make_event(int k, kdlp_pkg::event_kind_type kind);
         key_event_type ev;
         ev.key  = k[kdlp_pkg::KEY_NUM_W-1:0];
         ev.kind = kind;
         ev.last = 1'b0;
         return ev;
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      // advance the key state by one accepted scan item and queue its events
      function void note_scan(logic [kdlp_pkg::KEY_COUNT-1:0] raw);
         bit            down [kdlp_pkg::KEY_COUNT];
         key_event_type evs [$];
         key_event_type ev;
         int            others;
         bit            was_long;
         int unsigned   hold_now;
         others = 0;

         // debounce and hold time
         for (int k = 0; k < kdlp_pkg::KEY_COUNT; k++) begin
            if (!raw[k]) begin
               muted[k] = 1'b0;
               if (!confirmed[k])
                  sample_cnt[k] = '0;
            end else if (muted[k] || confirmed[k]) begin
               if (confirmed[k]) begin
                  hold_now   = held_ms[k] + scan_ms;
                  held_ms[k] = (hold_now > kdlp_pkg::HOLD_MAX)
                             ? kdlp_pkg::HOLD_MAX : hold_now[kdlp_pkg::HOLD_W-1:0];
               end
            end else begin
               if (sample_cnt[k] < press_samples)
                  sample_cnt[k]++;
               if (sample_cnt[k] >= press_samples) begin
                  confirmed[k] = 1'b1;
                  long_done[k] = 1'b0;
                  held_ms[k]   = '0;
               end
            end
         end

         // chord suppression, key 0 has priority
         down[0] = raw[0] && confirmed[0];
         for (int k = 1; k < kdlp_pkg::KEY_COUNT; k++) begin
            down[k] = raw[k] && (confirmed[k] || muted[k]);
            if (down[k])
               others++;
         end
         if (down[0] || others >= 2) begin
            for (int k = 1; k < kdlp_pkg::KEY_COUNT; k++)
               if (down[k]) begin
                  muted[k] = 1'b1;
                  clear_key(k);
               end
         end

         // long while held, and release events
         for (int k = 0; k < kdlp_pkg::KEY_COUNT; k++) begin
            if (muted[k] || !confirmed[k])
               continue;
            if (raw[k]) begin
               if (!long_done[k] && held_ms[k] >= long_ms) begin
                  long_done[k] = 1'b1;
                  evs.push_back(make_event(k, kdlp_pkg::EV_LONG));
               end
            end else begin
               was_long = long_done[k];
               hold_now = held_ms[k];
               clear_key(k);
               if (!was_long) begin
                  if (hold_now >= long_ms)
                     evs.push_back(make_event(k, kdlp_pkg::EV_LONG));
                  else if (hold_now + margin_ms < long_ms)
                     evs.push_back(make_event(k, kdlp_pkg::EV_SHORT));
               end
               evs.push_back(make_event(k, kdlp_pkg::EV_OFF));
            end
         end

         // final event of the scan carries last
         foreach (evs[i]) begin
            ev      = evs[i];
            ev.last = (i == evs.size() - 1);
            expected_events.push_back(ev);
         end
      endfunction

      function void report(string msg);
         fail_count++;
         if (fail_count <= 10)
            $display("%s", msg);
      endfunction

      // compare one accepted result item with the oldest expected event
      function void check_event(logic [kdlp_pkg::RSP_DATA_W-1:0] data, logic last);
         key_event_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("unexpected event: key %0d kind %0d last %0b",
                             data[1:0], data[3:2], last));
            return;
         end
         want = expected_events.pop_front();
         if (data[1:0] !== want.key || data[3:2] !== want.kind || last !== want.last
             || data[kdlp_pkg::RSP_DATA_W-1:kdlp_pkg::KEY_NUM_W+kdlp_pkg::EVENT_W] !== '0)
            report($sformatf({"event mismatch: expected key %0d kind %0d last %0b, ",
                              "got key %0d kind %0d last %0b pad %h"},
                             want.key, want.kind, want.last,
                             data[1:0], data[3:2], last,
                             data[kdlp_pkg::RSP_DATA_W-1:kdlp_pkg::KEY_NUM_W+kdlp_pkg::EVENT_W]));
      endfunction
   endclass

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [kdlp_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [kdlp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_we      = 1'b0;
   logic [kdlp_pkg::CSR_IDX_W-1:0]  csr_windex  = '0;
   logic [kdlp_pkg::CSR_DATA_W-1:0] csr_wdata   = '0;

   key_event_tracker tracker;
   int               burst_left    = 0;
   int               holdoff_asked = 0;
   int               holdoff_seen  = 0;
   int               holdoff_left  = 0;
   logic [31:0]      rx_cycle      = '0;

   key_debounce_long_press_chord uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_windex (csr_windex),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // offer one scan item in bursts with random gaps, note it once accepted
   task automatic send_scan(input logic [kdlp_pkg::KEY_COUNT-1:0] keys);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(kdlp_pkg::REQ_DATA_W - kdlp_pkg::KEY_COUNT){1'b0}}, keys};
      do @(posedge clock); while (!req_tready);
      tracker.note_scan(keys);
   endtask

   // held patterns with random content, mostly followed by a release, some noise
   task automatic random_runs(input int items, input int run_max);
      logic [kdlp_pkg::KEY_COUNT-1:0] keys;
      logic [31:0]                    rnd;
      int                             len;
      int                             sent;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 4) == 0) begin
            rnd  = $urandom;
            keys = rnd[kdlp_pkg::KEY_COUNT-1:0];
            len  = 1;
         end else begin
            rnd  = $urandom_range(1, 7);
            keys = rnd[kdlp_pkg::KEY_COUNT-1:0];
            len  = $urandom_range(1, run_max);
         end
         repeat (len) begin
            send_scan(keys);
            sent++;
         end
         if ($urandom_range(0, 9) < 7) begin
            len = $urandom_range(1, 2);
            repeat (len) begin
               send_scan('0);
               sent++;
            end
         end
      end
   endtask

   // stop offering and wait for all events plus the pipeline depth
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (20) @(posedge clock);
   endtask

   // write all four registers back to back while the block is idle
   task automatic program_regs(input logic [kdlp_pkg::SAMPLE_W-1:0] ps,
                               input logic [kdlp_pkg::INTERVAL_W-1:0] si,
                               input logic [kdlp_pkg::HOLD_W-1:0] lp,
                               input logic [kdlp_pkg::HOLD_W-1:0] lm);
      csr_we     <= 1'b1;
      csr_windex <= kdlp_pkg::CSR_PRESS_SAMPLES;
      csr_wdata  <= {{(kdlp_pkg::CSR_DATA_W - kdlp_pkg::SAMPLE_W){1'b0}}, ps};
      @(posedge clock);
      csr_windex <= kdlp_pkg::CSR_SCAN_INTERVAL;
      csr_wdata  <= {{(kdlp_pkg::CSR_DATA_W - kdlp_pkg::INTERVAL_W){1'b0}}, si};
      @(posedge clock);
      csr_windex <= kdlp_pkg::CSR_LONG_PRESS;
      csr_wdata  <= lp;
      @(posedge clock);
      csr_windex <= kdlp_pkg::CSR_LONG_MARGIN;
      csr_wdata  <= lm;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_regs(ps, si, lp, lm);
   endtask

   // result side: check accepted items, stall on a rotating pattern or a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            tracker.check_event(rsp_tdata, rsp_tlast);
         rx_cycle++;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else if (holdoff_seen != holdoff_asked) begin
            holdoff_seen = holdoff_asked;
            holdoff_left = 200;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_cycle[7:6])
               2'd0: rsp_tready <= 1'b1;
               2'd1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2'd2: rsp_tready <= (rx_cycle[1:0] == 2'd0);
               default: rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // main sequence
   initial begin
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: debounce, chords, short release
      foreach (DIRECTED_SCANS[i])
         send_scan(DIRECTED_SCANS[i]);
      settle();

      // quick long press with a margin band, receiver held off to back up the input
      program_regs(8'd2, 8'd50, 16'd200, 16'd60);
      holdoff_asked <= holdoff_asked + 1;
      random_runs(30, 10);
      settle();

      // confirm on first scan, long in the confirming scan, no margin
      program_regs(8'd0, 8'd1, 16'd0, 16'd0);
      random_runs(15, 4);
      settle();

      program_regs(8'd1, 8'd255, 16'd510, 16'd255);
      random_runs(20, 6);
      settle();

      // all registers at maximum: short runs never confirm a press
      program_regs(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
      random_runs(10, 8);
      settle();

      // huge margin: early releases give no short event
      program_regs(8'd4, 8'd100, 16'd300, 16'hFFFF);
      random_runs(20, 12);
      settle();

      if (tracker.fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
